>>> sv/gate_pass_counter_delayed_stop_core_defines.svh
// Assertion macros used by the gate pass counter engine.
`ifndef GATE_PASS_COUNTER_DELAYED_STOP_CORE_DEFINES_SVH
`define GATE_PASS_COUNTER_DELAYED_STOP_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define GPC_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define GPC_ASSERT_NEVER(name, clk, rst, cond, msg) \
   name: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GPC_ASSERT(name, clk, rst, prop, msg)
`define GPC_ASSERT_NEVER(name, clk, rst, cond, msg)
`endif

`endif

>>> sv/gpc_pkg.sv
// Types and constants shared by the gate pass counter modules.
`default_nettype none

package gpc_pkg;

   localparam int TIME_W     = 48;
   localparam int EDGES_W    = 8;
   localparam int SPEED_W    = 7;
   localparam int DELAY_MS_W = 14;
   localparam int DELAY_US_W = 24;
   localparam int COUNT_W    = 2;
   localparam int TOTAL_W    = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [SPEED_W-1:0]    SPEED_MAX      = 7'd100;
   localparam logic [DELAY_MS_W-1:0] DELAY_MAX      = 14'd10000;
   localparam logic [DELAY_US_W-1:0] US_PER_MS      = 24'd1000;
   localparam logic [SPEED_W-1:0]    SPEED_RESET    = 7'd20;
   localparam logic [DELAY_US_W-1:0] DELAY_US_RESET = 24'd500000;
   localparam logic [TIME_W-1:0]     TIME_MAX       = {TIME_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ENABLE     = 2'd0,
      CSR_SLOW_SPEED = 2'd1,
      CSR_STOP_DELAY = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                  enable;
      logic [SPEED_W-1:0]    slow_speed;
      logic [DELAY_US_W-1:0] stop_delay_us;
   } cfg_type;

   typedef struct packed {
      logic [TIME_W-1:0]  time_us;
      logic               moving;
      logic               level_active;
      logic [EDGES_W-1:0] edges_seen;
   } req_item_type;

   typedef struct packed {
      logic               detected;
      logic [TOTAL_W-1:0] edge_total;
      logic               stop_pending;
      logic [COUNT_W-1:0] passes_now;
      logic [COUNT_W-1:0] pass_just_counted;
      logic               stop_vehicle;
      logic [SPEED_W-1:0] slowdown_speed;
      logic               begin_slowdown;
   } rsp_item_type;

endpackage

`default_nettype wire

>>> sv/gpc_cfg.sv
// Configuration registers with range checks and the run-state clear pulse.
`default_nettype none

module gpc_cfg (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   input  wire logic [gpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gpc_pkg::DELAY_MS_W-1:0] csr_wdata,
   output gpc_pkg::cfg_type                   cfg,
   output logic                               clear_run
);
   import gpc_pkg::*;

   logic                  enable_ff, enable_in;
   logic [SPEED_W-1:0]    speed_ff, speed_in;
   logic [DELAY_US_W-1:0] delay_us_ff, delay_us_in;
   logic [SPEED_W-1:0]    speed_val;
   logic [DELAY_MS_W-1:0] delay_val;
   logic                  write_ok;

   assign speed_val = csr_wdata[SPEED_W-1:0];
   assign delay_val = csr_wdata;

   always_comb begin
      enable_in   = enable_ff;
      speed_in    = speed_ff;
      delay_us_in = delay_us_ff;
      write_ok    = 1'b0;
      if (csr_valid) begin
         case (csr_index)
            CSR_ENABLE: begin
               enable_in = csr_wdata[0];
               write_ok  = 1'b1;
            end
            CSR_SLOW_SPEED: begin
               if (speed_val <= SPEED_MAX) begin
                  speed_in = speed_val;
                  write_ok = 1'b1;
               end
            end
            CSR_STOP_DELAY: begin
               if (delay_val <= DELAY_MAX) begin
                  // Milliseconds are turned into microseconds once, at write time.
                  delay_us_in = DELAY_US_W'(delay_val) * US_PER_MS;
                  write_ok    = 1'b1;
               end
            end
            default: begin
               write_ok = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= 1'b0;
         speed_ff    <= SPEED_RESET;
         delay_us_ff <= DELAY_US_RESET;
      end else begin
         enable_ff   <= enable_in;
         speed_ff    <= speed_in;
         delay_us_ff <= delay_us_in;
      end
   end

   assign cfg.enable        = enable_ff;
   assign cfg.slow_speed    = speed_ff;
   assign cfg.stop_delay_us = delay_us_ff;
   assign clear_run         = write_ok;

endmodule

`default_nettype wire

>>> sv/gpc_engine.sv
// Pass counting state and the per-poll decision logic.
`default_nettype none
`include "gate_pass_counter_delayed_stop_core_defines.svh"

module gpc_engine #(
   parameter int REARM_HOLDOFF_US = 2000000,
   parameter int PASSES_TO_STOP   = 2
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire gpc_pkg::req_item_type item,
   input  wire gpc_pkg::cfg_type      cfg,
   input  wire logic                  clear_run,
   output gpc_pkg::rsp_item_type      result
);
   import gpc_pkg::*;

   localparam logic [COUNT_W-1:0] PASS_LIMIT = COUNT_W'(PASSES_TO_STOP);
   localparam logic [TIME_W:0]    HOLDOFF    = (TIME_W+1)'(REARM_HOLDOFF_US);

   logic [COUNT_W-1:0] pass_count_ff, pass_count_in;
   logic               stopping_ff, stopping_in;
   logic [TIME_W-1:0]  rearm_dl_ff, rearm_dl_in;
   logic [TIME_W-1:0]  stop_dl_ff, stop_dl_in;
   logic [TOTAL_W-1:0] edge_acc_ff, edge_acc_in;

   logic [TIME_W:0]    rearm_sum, stop_sum;
   logic [COUNT_W-1:0] pass_next;
   logic               count_ok, begin_seq, stop_fire;

   assign rearm_sum = {1'b0, item.time_us} + HOLDOFF;
   assign stop_sum  = {1'b0, item.time_us} + (TIME_W+1)'(cfg.stop_delay_us);
   assign pass_next = pass_count_ff + 1'b1;

   assign count_ok  = item.moving && (item.edges_seen != '0) && cfg.enable
                      && (item.time_us >= rearm_dl_ff) && !stopping_ff;
   assign begin_seq = count_ok && (pass_next >= PASS_LIMIT);

   // A freshly armed deadline is already reached only for a zero delay, or
   // when the sum saturates at the top of the time range and now sits there.
   assign stop_fire = item.moving &&
                      ((stopping_ff && (item.time_us >= stop_dl_ff)) ||
                       (begin_seq && ((cfg.stop_delay_us == '0) ||
                                      (item.time_us == TIME_MAX))));

   always_comb begin
      pass_count_in = pass_count_ff;
      stopping_in   = stopping_ff;
      rearm_dl_in   = rearm_dl_ff;
      stop_dl_in    = stop_dl_ff;
      edge_acc_in   = edge_acc_ff;
      if (clear_run) begin
         pass_count_in = '0;
         stopping_in   = 1'b0;
         rearm_dl_in   = '0;
         stop_dl_in    = '0;
      end else if (step) begin
         edge_acc_in = edge_acc_ff + TOTAL_W'(item.edges_seen);
         if (!item.moving) begin
            pass_count_in = '0;
            stopping_in   = 1'b0;
            stop_dl_in    = '0;
         end else if (count_ok) begin
            pass_count_in = pass_next;
            rearm_dl_in   = rearm_sum[TIME_W] ? TIME_MAX : rearm_sum[TIME_W-1:0];
            if (begin_seq) begin
               stopping_in = 1'b1;
               stop_dl_in  = stop_sum[TIME_W] ? TIME_MAX : stop_sum[TIME_W-1:0];
            end
         end
         if (stop_fire) begin
            stopping_in   = 1'b0;
            pass_count_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pass_count_ff <= '0;
         stopping_ff   <= 1'b0;
         rearm_dl_ff   <= '0;
         stop_dl_ff    <= '0;
         edge_acc_ff   <= '0;
      end else begin
         pass_count_ff <= pass_count_in;
         stopping_ff   <= stopping_in;
         rearm_dl_ff   <= rearm_dl_in;
         stop_dl_ff    <= stop_dl_in;
         edge_acc_ff   <= edge_acc_in;
      end
   end

   always_comb begin
      result.begin_slowdown    = begin_seq;
      result.slowdown_speed    = begin_seq ? cfg.slow_speed : '0;
      result.stop_vehicle      = stop_fire;
      result.pass_just_counted = count_ok ? pass_next : '0;
      result.passes_now        = pass_count_in;
      result.stop_pending      = stopping_in;
      result.edge_total        = edge_acc_in;
      result.detected          = item.level_active;
   end

   `GPC_ASSERT_NEVER(a_count_in_range, clock, reset, pass_count_ff > PASS_LIMIT,
      "pass count ran past the stop threshold")
   `GPC_ASSERT(a_stopping_at_limit, clock, reset, stopping_ff |-> pass_count_ff == PASS_LIMIT,
      "stop pending without the final pass counted")
   `GPC_ASSERT(a_begin_arms, clock, reset,
      (step && !clear_run && begin_seq && !stop_fire) |=> stopping_ff,
      "slowdown began but no stop was armed")
   `GPC_ASSERT(a_clear_run, clock, reset,
      clear_run |=> (pass_count_ff == '0) && !stopping_ff && (stop_dl_ff == '0),
      "configuration write did not clear the run state")

endmodule

`default_nettype wire

>>> sv/gate_pass_counter_delayed_stop_core.sv
// Top level of the gate pass counter with delayed stop.
`default_nettype none

// Each req beat is one sensor poll and produces exactly one rsp beat. A poll
// passes through an input register, the pass counting decision is made in
// combinational logic, and the result lands in an output register, so a new
// poll is taken every cycle while the result side keeps up: throughput is one
// beat per clock, and rsp_tvalid rises once the result of the poll has moved
// from the input register into the output register. The rate is set by the
// state update in the engine, whose pass count and deadlines feed straight
// into the next poll. A stalled rsp side holds one result in the output
// register and one poll in the input register before req_tready drops.
// Configuration writes are always taken; a valid write clears the pass
// count, the pending stop and both deadlines, and a write that is out of
// range or to an unknown index changes nothing. Writes are meant to happen
// only while no poll is in flight.
module gate_pass_counter_delayed_stop_core #(
   parameter int REARM_HOLDOFF_US = 2000000,
   parameter int PASSES_TO_STOP   = 2
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // req beat: edges_seen[7:0], level_active[8], moving[9], time_us[57:10], zero pad
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [63:0]                    req_tdata,
   // rsp beat: begin_slowdown[0], slowdown_speed[7:1], stop_vehicle[8],
   // pass_just_counted[10:9], passes_now[12:11], stop_pending[13],
   // edge_total[45:14], detected[46], zero pad
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [47:0]                         rsp_tdata,
   // Configuration: 0 enable, 1 slow speed percent, 2 stop delay in milliseconds.
   input  wire logic                           csr_valid,
   output logic                                csr_ready,
   input  wire logic [gpc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [gpc_pkg::DELAY_MS_W-1:0] csr_wdata
);
   import gpc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff, in_item_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   logic         advance, step, req_fire;
   cfg_type      cfg;
   logic         clear_run;
   rsp_item_type result;

   // The output register can load when it is empty or being drained.
   assign advance    = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign req_fire   = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_fire) begin
         in_valid_in             = 1'b1;
         in_item_in.edges_seen   = req_tdata[7:0];
         in_item_in.level_active = req_tdata[8];
         in_item_in.moving       = req_tdata[9];
         in_item_in.time_us      = req_tdata[57:10];
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_item_in  = result;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers carry no reset; their valid bits guard them.
   always_ff @(posedge clock) begin
      in_item_ff  <= in_item_in;
      out_item_ff <= out_item_in;
   end

   gpc_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .clear_run (clear_run)
   );

   gpc_engine #(
      .REARM_HOLDOFF_US (REARM_HOLDOFF_US),
      .PASSES_TO_STOP   (PASSES_TO_STOP)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (in_item_ff),
      .cfg       (cfg),
      .clear_run (clear_run),
      .result    (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_item_ff};

endmodule

`default_nettype wire

>>> tb/tb_gate_pass_counter_delayed_stop_core.sv
// Self-checking testbench for the gate pass counter with delayed stop.
`timescale 1ns / 1ps

module tb_gate_pass_counter_delayed_stop_core;
   import gpc_pkg::*;

   // The block is built with its default holdoff and pass target; the
   // predictor below uses the same values.
   localparam int HOLDOFF_US      = 2000000;
   localparam int PASSES_FOR_STOP = 2;

   // Index 3 fits the index port but names no register.
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int PHASES        = 12;
   localparam int POLLS_A_PHASE = 155;
   localparam int LONG_HOLD     = 400;
   localparam int MAX_PRINTED   = 40;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [DELAY_MS_W-1:0] csr_wdata = '0;

   gate_pass_counter_delayed_stop_core #(
      .REARM_HOLDOFF_US(HOLDOFF_US),
      .PASSES_TO_STOP  (PASSES_FOR_STOP)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 8 ns clock period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Predictor. It holds its own copy of the settings and the run state and
   // is advanced once per accepted poll beat, in acceptance order.
   // ---------------------------------------------------------------------
   logic                  cfg_enable     = 1'b0;
   logic [SPEED_W-1:0]    cfg_slow_speed = SPEED_RESET;
   logic [DELAY_MS_W-1:0] cfg_delay_ms   = 14'd500;

   logic [COUNT_W-1:0] passes       = '0;
   logic               stop_armed   = 1'b0;
   logic [TIME_W-1:0]  rearm_due_us = '0;
   logic [TIME_W-1:0]  stop_due_us  = '0;
   logic [TOTAL_W-1:0] edge_sum     = '0;

   // Deadlines never wrap: a sum past the top of the time range pins to it.
   function automatic logic [TIME_W-1:0] deadline_after(input logic [TIME_W-1:0] from_us,
                                                        input logic [TIME_W-1:0] span_us);
      logic [TIME_W:0] sum;
      sum = {1'b0, from_us} + {1'b0, span_us};
      return sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
   endfunction

   // A register write that is taken also drops the current run: pass count,
   // pending stop and both deadlines. Out of range values and the unused
   // index leave everything as it was.
   function automatic void apply_csr_write(input logic [CSR_IDX_W-1:0] idx,
                                           input logic [DELAY_MS_W-1:0] data);
      logic taken;
      taken = 1'b1;
      case (idx)
         CSR_ENABLE: cfg_enable = data[0];
         CSR_SLOW_SPEED: begin
            if (data[SPEED_W-1:0] > SPEED_MAX) taken = 1'b0;
            else cfg_slow_speed = data[SPEED_W-1:0];
         end
         CSR_STOP_DELAY: begin
            if (data > DELAY_MAX) taken = 1'b0;
            else cfg_delay_ms = data;
         end
         default: taken = 1'b0;
      endcase
      if (taken) begin
         passes       = '0;
         stop_armed   = 1'b0;
         rearm_due_us = '0;
         stop_due_us  = '0;
      end
   endfunction

   function automatic rsp_item_type predict_poll(input req_item_type poll);
      rsp_item_type r;
      r = '0;
      edge_sum = edge_sum + TOTAL_W'(poll.edges_seen);
      if (!poll.moving) begin
         // A parked vehicle abandons any pass sequence; the rearm deadline stays.
         passes      = '0;
         stop_armed  = 1'b0;
         stop_due_us = '0;
      end else if (poll.edges_seen != 0 && cfg_enable && poll.time_us >= rearm_due_us
                   && !stop_armed) begin
         passes       = passes + 1'b1;
         rearm_due_us = deadline_after(poll.time_us, TIME_W'(HOLDOFF_US));
         r.pass_just_counted = passes;
         if (passes >= PASSES_FOR_STOP) begin
            stop_armed       = 1'b1;
            stop_due_us      = deadline_after(poll.time_us,
                                              TIME_W'(cfg_delay_ms) * TIME_W'(US_PER_MS));
            r.begin_slowdown = 1'b1;
            r.slowdown_speed = cfg_slow_speed;
         end
      end
      // The stop can land on the same poll that armed it when the delay is zero.
      if (poll.moving && stop_armed && poll.time_us >= stop_due_us) begin
         r.stop_vehicle = 1'b1;
         stop_armed     = 1'b0;
         passes         = '0;
      end
      r.passes_now   = passes;
      r.stop_pending = stop_armed;
      r.edge_total   = edge_sum;
      r.detected     = poll.level_active;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Shared bookkeeping between the processes. Every variable but the poll
   // queue has exactly one writing process.
   // ---------------------------------------------------------------------
   req_item_type polls_to_send[$];     // filled by the stimulus, drained by the driver
   rsp_item_type pending_results[$];   // owned by the monitor
   int           req_accepts   = 0;    // monitor: poll beats taken so far
   int           req_seen      = 0;    // driver: accepts it has already acted on
   int           rsp_count     = 0;
   int           mismatches    = 0;
   int           hold_requests = 0;    // stimulus asks for a long result stall
   int           hold_served   = 0;    // result side has started that many
   bit           quiet_tail    = 1'b0; // no idling on either side from here on
   longint       cycles        = 0;

   // ---------------------------------------------------------------------
   // Poll driver. Inputs change on the falling edge. A beat stays on the
   // bus until the monitor has seen it taken.
   // ---------------------------------------------------------------------
   int           feed_gap       = 0;
   int           feed_mode_left = 0;
   bit           feed_busy      = 1'b0;
   req_item_type next_poll;

   always @(negedge clock) begin
      // Alternate between stretches with random idling and stretches without.
      if (feed_mode_left == 0) begin
         feed_mode_left = $urandom_range(20, 200);
         feed_busy      = 1'($urandom_range(0, 1));
      end else begin
         feed_mode_left--;
      end
      if (req_tvalid && req_accepts == req_seen) begin
         // Beat still waiting for req_tready; keep it steady.
      end else begin
         req_seen = req_accepts;
         if (feed_gap > 0) begin
            feed_gap--;
            req_tvalid <= 1'b0;
         end else if (polls_to_send.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (feed_busy && !quiet_tail && $urandom_range(0, 5) == 0) begin
            // This cycle starts an idle burst, and feed_gap more idle cycles follow it.
            feed_gap = $urandom_range(0, 9);
            req_tvalid <= 1'b0;
         end else begin
            next_poll = polls_to_send.pop_front();
            req_tdata  <= {6'b0, next_poll};
            req_tvalid <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result side back-pressure: random stall bursts, calm stretches, and a
   // long hold-off on request so the block fills up and stalls its input.
   // ---------------------------------------------------------------------
   int rsp_stall_left = 0;
   int rsp_hold_left  = 0;
   int rsp_mode_left  = 0;
   bit rsp_busy       = 1'b0;

   always @(negedge clock) begin
      if (rsp_mode_left == 0) begin
         rsp_mode_left = $urandom_range(20, 200);
         rsp_busy      = 1'($urandom_range(0, 1));
      end else begin
         rsp_mode_left--;
      end
      if (hold_served != hold_requests) begin
         hold_served   = hold_requests;
         rsp_hold_left = LONG_HOLD;
      end
      if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_busy && !quiet_tail && $urandom_range(0, 5) == 0) begin
         rsp_stall_left = $urandom_range(0, 9);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Monitor. Both channels are sampled on the rising edge. An accepted
   // poll is run through the predictor right away; an accepted result is
   // compared with the oldest prediction.
   // ---------------------------------------------------------------------
   task automatic report_mismatch(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED)
         $display("[%0t] result beat %0d: %s", $realtime, rsp_count, what);
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s is 0x%0h, expected 0x%0h", name, got, want));
   endtask

   req_item_type taken_poll;
   rsp_item_type got_rsp;
   rsp_item_type want_rsp;

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            taken_poll = req_tdata[$bits(req_item_type)-1:0];
            pending_results.push_back(predict_poll(taken_poll));
            req_accepts++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got_rsp = rsp_tdata[$bits(rsp_item_type)-1:0];
            if (pending_results.size() == 0) begin
               report_mismatch("result beat arrived with no poll outstanding");
            end else begin
               want_rsp = pending_results.pop_front();
               check_field("begin_slowdown", 32'(got_rsp.begin_slowdown),
                           32'(want_rsp.begin_slowdown));
               check_field("slowdown_speed", 32'(got_rsp.slowdown_speed),
                           32'(want_rsp.slowdown_speed));
               check_field("stop_vehicle", 32'(got_rsp.stop_vehicle),
                           32'(want_rsp.stop_vehicle));
               check_field("pass_just_counted", 32'(got_rsp.pass_just_counted),
                           32'(want_rsp.pass_just_counted));
               check_field("passes_now", 32'(got_rsp.passes_now),
                           32'(want_rsp.passes_now));
               check_field("stop_pending", 32'(got_rsp.stop_pending),
                           32'(want_rsp.stop_pending));
               check_field("edge_total", got_rsp.edge_total, want_rsp.edge_total);
               check_field("detected", 32'(got_rsp.detected), 32'(want_rsp.detected));
            end
            rsp_count++;
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("** gate_pass_counter_delayed_stop_core: FAILED **");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers.
   // ---------------------------------------------------------------------
   logic [TIME_W-1:0] gen_time    = '0;
   int                polls_queued = 0;

   // Level is random on every poll so the copy-through is always exercised.
   task automatic send_poll(input logic [EDGES_W-1:0] edges, input logic moving,
                            input logic [TIME_W-1:0] at_us);
      req_item_type p;
      p.edges_seen   = edges;
      p.level_active = 1'($urandom_range(0, 1));
      p.moving       = moving;
      p.time_us      = at_us;
      polls_to_send.push_back(p);
      polls_queued++;
   endtask

   function automatic logic [EDGES_W-1:0] random_edges();
      case ($urandom_range(0, 5))
         0, 1: return '0;
         2: return 8'd255;
         3: return 8'd1;
         default: return EDGES_W'($urandom_range(1, 254));
      endcase
   endfunction

   function automatic logic [EDGES_W-1:0] some_edges();
      case ($urandom_range(0, 3))
         0: return 8'd1;
         1: return 8'd255;
         default: return EDGES_W'($urandom_range(1, 255));
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] random_step();
      case ($urandom_range(0, 4))
         0: return '0;
         1: return TIME_W'($urandom_range(1, 5000));
         2: return TIME_W'($urandom_range(0, 1000000));
         3: return TIME_W'($urandom_range(1900000, 2100000));
         default: return TIME_W'($urandom_range(0, 12000000));
      endcase
   endfunction

   // Waits until no poll is queued or in flight and every result is in,
   // then lets the two-stage pipe run dry before anything is reconfigured.
   task automatic settle();
      while (polls_to_send.size() != 0 || req_tvalid) @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [DELAY_MS_W-1:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      apply_csr_write(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // A well-formed stop sequence with random content: a first pass, some
   // polls inside the holdoff, a second pass at or near the rearm time, polls
   // while the stop is pending, and the stop at or near its deadline.
   task automatic run_stop_sequence();
      logic [TIME_W-1:0] first_at;
      logic [TIME_W-1:0] second_at;
      logic [TIME_W-1:0] stop_at;
      longint            span;
      if ($urandom_range(0, 1) == 1) begin
         gen_time += TIME_W'($urandom_range(0, 1000));
         send_poll(random_edges(), 1'b0, gen_time);
      end
      gen_time += TIME_W'(HOLDOFF_US) + TIME_W'($urandom_range(0, 2));
      send_poll(some_edges(), 1'b1, gen_time);
      first_at = gen_time;
      repeat ($urandom_range(0, 3)) begin
         gen_time += TIME_W'($urandom_range(0, 400000));
         send_poll(random_edges(), 1'b1, gen_time);
      end
      second_at = first_at + TIME_W'(HOLDOFF_US);
      case ($urandom_range(0, 3))
         0: begin
            // One microsecond short of the rearm time: must not count.
            gen_time = second_at - 1;
            send_poll(some_edges(), 1'b1, gen_time);
         end
         3: second_at += TIME_W'($urandom_range(1, 300000));
         default: ;
      endcase
      gen_time = second_at;
      send_poll(some_edges(), 1'b1, gen_time);
      stop_at = second_at + TIME_W'(cfg_delay_ms) * TIME_W'(US_PER_MS);
      repeat ($urandom_range(0, 3)) begin
         span = longint'(stop_at - gen_time);
         if (span > 1) gen_time += TIME_W'($urandom_range(0, int'(span - 1)));
         send_poll(random_edges(), $urandom_range(0, 15) != 0, gen_time);
      end
      if ($urandom_range(0, 3) == 0 && stop_at > gen_time) begin
         gen_time = stop_at - 1;
         send_poll(random_edges(), 1'b1, gen_time);
      end
      gen_time = stop_at;
      if ($urandom_range(0, 2) == 0) gen_time += TIME_W'($urandom_range(1, 500000));
      send_poll(random_edges(), 1'b1, gen_time);
   endtask

   task automatic run_noise();
      repeat ($urandom_range(1, 6)) begin
         gen_time += random_step();
         send_poll(random_edges(), $urandom_range(0, 9) != 0, gen_time);
      end
   endtask

   function automatic logic [DELAY_MS_W-1:0] pick_speed();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return DELAY_MS_W'(SPEED_MAX);
         2, 3: return DELAY_MS_W'($urandom_range(0, 100));
         4: return DELAY_MS_W'($urandom_range(101, 127));
         default: return {7'($urandom_range(0, 127)), 7'($urandom_range(0, 100))};
      endcase
   endfunction

   function automatic logic [DELAY_MS_W-1:0] pick_delay();
      case ($urandom_range(0, 5))
         0: return '0;
         1: return DELAY_MAX;
         2, 3: return DELAY_MS_W'($urandom_range(0, 3000));
         4: return DELAY_MS_W'($urandom_range(0, 10000));
         default: return DELAY_MS_W'($urandom_range(10001, 16383));
      endcase
   endfunction

   // Every phase rewrites enable, which also starts it from a clean run
   // state; the other registers are rewritten at random, out of range
   // values and the unused index included.
   task automatic configure_phase(input int phase);
      logic en;
      en = (phase % 5) != 2;
      write_csr(CSR_ENABLE, {13'($urandom_range(0, 8191)), en});
      if ($urandom_range(0, 2) != 0) write_csr(CSR_SLOW_SPEED, pick_speed());
      if ($urandom_range(0, 2) != 0) write_csr(CSR_STOP_DELAY, pick_delay());
      if ($urandom_range(0, 4) == 0)
         write_csr(CSR_UNUSED, DELAY_MS_W'($urandom_range(0, 16383)));
      // With the deadlines cleared the clock may restart anywhere.
      case (phase % 4)
         0: gen_time = '0;
         1: gen_time = {16'($urandom_range(0, 16'hFFFE)), 32'($urandom())};
         2: gen_time = TIME_W'($urandom());
         default: gen_time = TIME_MAX - TIME_W'(48'd4000000000) - TIME_W'($urandom_range(0, 1000));
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Main sequence.
   // ---------------------------------------------------------------------
   int phase_end;

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Out of reset counting is disabled, even with a full edge count.
      send_poll(8'd255, 1'b1, 48'd0);
      send_poll(8'd0, 1'b1, 48'd0);
      settle();
      write_csr(CSR_ENABLE, 14'd1);

      // First pass, holdoff, second pass exactly at rearm with the reset
      // speed and delay, edges ignored while the stop is pending, then the
      // stop exactly at its deadline. The rearm deadline survives the stop.
      send_poll(8'd1, 1'b1, 48'd0);
      send_poll(8'd5, 1'b1, 48'd1000);
      send_poll(8'd1, 1'b1, 48'd1999999);
      send_poll(8'd1, 1'b1, 48'd2000000);
      send_poll(8'd3, 1'b1, 48'd2100000);
      send_poll(8'd0, 1'b1, 48'd2499999);
      send_poll(8'd0, 1'b1, 48'd2500000);
      send_poll(8'd1, 1'b1, 48'd3000000);
      send_poll(8'd1, 1'b1, 48'd4500000);
      // Parking drops the pass just counted.
      send_poll(8'd0, 1'b0, 48'd4600000);
      settle();

      // Top speed with zero delay. Out of range writes and the unused index
      // between the two passes must leave the pass count alone.
      write_csr(CSR_SLOW_SPEED, DELAY_MS_W'(SPEED_MAX));
      write_csr(CSR_STOP_DELAY, 14'd0);
      send_poll(8'd1, 1'b1, 48'd10000000);
      settle();
      write_csr(CSR_SLOW_SPEED, 14'd101);
      write_csr(CSR_STOP_DELAY, 14'd10001);
      write_csr(CSR_UNUSED, 14'h3FFF);
      write_csr(CSR_SLOW_SPEED, 14'd127);
      write_csr(CSR_STOP_DELAY, 14'h3FFF);
      send_poll(8'd2, 1'b1, 48'd12000000);
      settle();

      // Excess bits are dropped: speed 0 from a wide value, enable from bit 0.
      // Near the top of the time range both deadlines saturate, so the stop
      // comes on the same poll even with the longest delay.
      write_csr(CSR_SLOW_SPEED, 14'h3F80);
      write_csr(CSR_STOP_DELAY, DELAY_MAX);
      write_csr(CSR_ENABLE, 14'h3FFF);
      send_poll(8'd1, 1'b1, TIME_MAX - 48'd1000);
      send_poll(8'd1, 1'b1, TIME_MAX - 48'd1);
      send_poll(8'd1, 1'b1, TIME_MAX);
      send_poll(8'd255, 1'b0, TIME_MAX);
      settle();
      write_csr(CSR_ENABLE, 14'h3FFE);
      send_poll(8'd9, 1'b1, 48'd0);

      // Random phases, each under its own settings.
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         configure_phase(phase);
         if (phase == 3 || phase == 8) hold_requests++;
         if (phase == PHASES - 1) quiet_tail = 1'b1;
         phase_end = polls_queued + POLLS_A_PHASE;
         while (polls_queued < phase_end) begin
            if ($urandom_range(0, 3) != 0) run_stop_sequence();
            else run_noise();
         end
      end

      settle();
      if (mismatches == 0) begin
         $display("** gate_pass_counter_delayed_stop_core: PASSED **");
      end else begin
         $display("** gate_pass_counter_delayed_stop_core: FAILED **");
      end
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/gpc_pkg.sv
sv/gpc_cfg.sv
sv/gpc_engine.sv
sv/gate_pass_counter_delayed_stop_core.sv
tb/tb_gate_pass_counter_delayed_stop_core.sv
